// File: hw/rtl/pseg_pkg.sv
// ============================================================================
// pseg_pkg
// Shared constants and types for the point-to-segment distance core.
// ============================================================================
package pseg_pkg;

    localparam int COORD_BITS_DEF = 16;   // default coordinate width
    localparam int DIST_BITS      = 34;   // width of the dist_sq result
    localparam int TOL_BITS       = 16;   // width of the tolerance register

    // Which squared length becomes the result
    typedef enum logic [1:0] {
        SEL_AP  = 2'b00,   // projection before A, or degenerate segment
        SEL_BP  = 2'b01,   // projection past B
        SEL_MID = 2'b10    // projection inside the segment, needs the divide
    } sel_t;

    // Control that travels alongside the data through the pipeline
    typedef struct packed {
        logic valid;
        sel_t sel;
    } ctl_t;

endpackage

// File: hw/rtl/pseg_ifs.sv
// ============================================================================
// pseg_ifs
// Valid/ready channel interfaces for the query and result streams.
// ============================================================================
interface pseg_query_if #(
    parameter int COORD_BITS = pseg_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic signed [COORD_BITS-1:0] end_a_x;
    logic signed [COORD_BITS-1:0] end_a_y;
    logic signed [COORD_BITS-1:0] end_a_z;
    logic signed [COORD_BITS-1:0] end_b_x;
    logic signed [COORD_BITS-1:0] end_b_y;
    logic signed [COORD_BITS-1:0] end_b_z;

    modport source (
        output valid, point_x, point_y, point_z,
               end_a_x, end_a_y, end_a_z, end_b_x, end_b_y, end_b_z,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z,
               end_a_x, end_a_y, end_a_z, end_b_x, end_b_y, end_b_z,
        output ready
    );
endinterface

interface pseg_result_if;
    logic                             valid;
    logic                             ready;
    logic [pseg_pkg::DIST_BITS-1:0]   dist_sq;
    logic                             on_segment;

    modport source (output valid, dist_sq, on_segment, input ready);
    modport sink   (input valid, dist_sq, on_segment, output ready);
endinterface

// File: hw/rtl/pseg_front.sv
// ============================================================================
// pseg_front
// Front end: differences, products, dot sums, clamp decision and tnum^2.
// Four register stages.
// ============================================================================
module pseg_front #(
    parameter int COORD_BITS = pseg_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [COORD_BITS-1:0]      point_x,
    input  logic signed [COORD_BITS-1:0]      point_y,
    input  logic signed [COORD_BITS-1:0]      point_z,
    input  logic signed [COORD_BITS-1:0]      end_a_x,
    input  logic signed [COORD_BITS-1:0]      end_a_y,
    input  logic signed [COORD_BITS-1:0]      end_a_z,
    input  logic signed [COORD_BITS-1:0]      end_b_x,
    input  logic signed [COORD_BITS-1:0]      end_b_y,
    input  logic signed [COORD_BITS-1:0]      end_b_z,
    output pseg_pkg::ctl_t                    ctl,
    output logic [2*(2*COORD_BITS+2)-1:0]     tsq,
    output logic [2*COORD_BITS+1:0]           ab2,
    output logic [2*COORD_BITS+1:0]           ap2,
    output logic [2*COORD_BITS+1:0]           bp2
);

    localparam int D = COORD_BITS + 1;   // difference width
    localparam int W = 2 * D;            // product / squared length width

    logic signed [COORD_BITS-1:0] p [3];
    logic signed [COORD_BITS-1:0] a [3];
    logic signed [COORD_BITS-1:0] b [3];

    assign p[0] = point_x;
    assign p[1] = point_y;
    assign p[2] = point_z;
    assign a[0] = end_a_x;
    assign a[1] = end_a_y;
    assign a[2] = end_a_z;
    assign b[0] = end_b_x;
    assign b[1] = end_b_y;
    assign b[2] = end_b_z;

    // stage 1: AP = P-A, AB = B-A, BP = P-B
    logic signed [D-1:0] d_next [3];
    logic signed [D-1:0] e_next [3];
    logic signed [D-1:0] f_next [3];
    logic signed [D-1:0] d_reg  [3];
    logic signed [D-1:0] e_reg  [3];
    logic signed [D-1:0] f_reg  [3];
    logic                v1_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_next[i] = D'(p[i]) - D'(a[i]);
            e_next[i] = D'(b[i]) - D'(a[i]);
            f_next[i] = D'(p[i]) - D'(b[i]);
        end
    end

    // stage 2: per-axis products
    logic signed [W-1:0] sd_next [3];
    logic signed [W-1:0] se_next [3];
    logic signed [W-1:0] sf_next [3];
    logic signed [W-1:0] de_next [3];
    logic signed [W-1:0] sd_reg  [3];
    logic signed [W-1:0] se_reg  [3];
    logic signed [W-1:0] sf_reg  [3];
    logic signed [W-1:0] de_reg  [3];
    logic                v2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sd_next[i] = W'(d_reg[i]) * W'(d_reg[i]);
            se_next[i] = W'(e_reg[i]) * W'(e_reg[i]);
            sf_next[i] = W'(f_reg[i]) * W'(f_reg[i]);
            de_next[i] = W'(d_reg[i]) * W'(e_reg[i]);
        end
    end

    // stage 3: squared lengths and the dot product
    logic [W-1:0]        ap2_next;
    logic [W-1:0]        ab2_next;
    logic [W-1:0]        bp2_next;
    logic signed [W:0]   tnum_next;
    logic [W-1:0]        ap2_reg;
    logic [W-1:0]        ab2_reg;
    logic [W-1:0]        bp2_reg;
    logic signed [W:0]   tnum_reg;
    logic                v3_reg;

    always_comb
    begin
        ap2_next  = $unsigned(sd_reg[0]) + $unsigned(sd_reg[1]) + $unsigned(sd_reg[2]);
        ab2_next  = $unsigned(se_reg[0]) + $unsigned(se_reg[1]) + $unsigned(se_reg[2]);
        bp2_next  = $unsigned(sf_reg[0]) + $unsigned(sf_reg[1]) + $unsigned(sf_reg[2]);
        tnum_next = (W+1)'(de_reg[0]) + (W+1)'(de_reg[1]) + (W+1)'(de_reg[2]);
    end

    // stage 4: clamp decision and tnum^2 for the divide
    logic [W-1:0]        ut;
    pseg_pkg::sel_t      sel_next;
    logic [2*W-1:0]      tsq_next;
    pseg_pkg::ctl_t      ctl_reg;
    logic [2*W-1:0]      tsq_reg;
    logic [W-1:0]        ab2_4_reg;
    logic [W-1:0]        ap2_4_reg;
    logic [W-1:0]        bp2_4_reg;

    always_comb
    begin
        ut = tnum_reg[W-1:0];
        if (ab2_reg == '0 || tnum_reg[W] || tnum_reg == '0)
        begin
            sel_next = pseg_pkg::SEL_AP;
        end
        else if (ut >= ab2_reg)
        begin
            sel_next = pseg_pkg::SEL_BP;
        end
        else
        begin
            sel_next = pseg_pkg::SEL_MID;
        end
        tsq_next = {{W{1'b0}}, ut} * {{W{1'b0}}, ut};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            ctl_reg <= '0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            ctl_reg.valid <= v3_reg;
            ctl_reg.sel   <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg     <= d_next;
            e_reg     <= e_next;
            f_reg     <= f_next;
            sd_reg    <= sd_next;
            se_reg    <= se_next;
            sf_reg    <= sf_next;
            de_reg    <= de_next;
            ap2_reg   <= ap2_next;
            ab2_reg   <= ab2_next;
            bp2_reg   <= bp2_next;
            tnum_reg  <= tnum_next;
            tsq_reg   <= tsq_next;
            ab2_4_reg <= ab2_reg;
            ap2_4_reg <= ap2_reg;
            bp2_4_reg <= bp2_reg;
        end
    end

    assign ctl = ctl_reg;
    assign tsq = tsq_reg;
    assign ab2 = ab2_4_reg;
    assign ap2 = ap2_4_reg;
    assign bp2 = bp2_4_reg;

endmodule

// File: hw/rtl/pseg_divider.sv
// ============================================================================
// pseg_divider
// Pipelined restoring divider: one quotient bit per stage, W stages.
// Quotient must fit W bits (numerator below divisor * 2^W).
// ============================================================================
module pseg_divider #(
    parameter int W = 2 * pseg_pkg::COORD_BITS_DEF + 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  pseg_pkg::ctl_t   ctl_in,
    input  logic [2*W-1:0]   num_in,
    input  logic [W-1:0]     den_in,
    input  logic [W-1:0]     ap2_in,
    input  logic [W-1:0]     bp2_in,
    output pseg_pkg::ctl_t   ctl_out,
    output logic [W-1:0]     quo,
    output logic             rem_nz,
    output logic [W-1:0]     ap2_out,
    output logic [W-1:0]     bp2_out
);

    pseg_pkg::ctl_t ctl_reg [W];
    logic [W-1:0]   rem_reg [W];
    logic [W-1:0]   low_reg [W];   // numerator bits not yet shifted in
    logic [W-1:0]   quo_reg [W];
    logic [W-1:0]   den_reg [W];
    logic [W-1:0]   ap2_reg [W];
    logic [W-1:0]   bp2_reg [W];

    for (genvar k = 0; k < W; k++)
    begin : g_step
        pseg_pkg::ctl_t ctl_k;
        logic [W-1:0]   rem_k;
        logic [W-1:0]   low_k;
        logic [W-1:0]   quo_k;
        logic [W-1:0]   den_k;
        logic [W-1:0]   ap2_k;
        logic [W-1:0]   bp2_k;
        logic [W:0]     trial;
        logic [W:0]     diff;

        if (k == 0)
        begin : g_first
            assign ctl_k = ctl_in;
            assign rem_k = num_in[2*W-1:W];
            assign low_k = num_in[W-1:0];
            assign quo_k = '0;
            assign den_k = den_in;
            assign ap2_k = ap2_in;
            assign bp2_k = bp2_in;
        end
        else
        begin : g_rest
            assign ctl_k = ctl_reg[k-1];
            assign rem_k = rem_reg[k-1];
            assign low_k = low_reg[k-1];
            assign quo_k = quo_reg[k-1];
            assign den_k = den_reg[k-1];
            assign ap2_k = ap2_reg[k-1];
            assign bp2_k = bp2_reg[k-1];
        end

        always_comb
        begin
            trial = {rem_k, low_k[W-1]};
            diff  = trial - {1'b0, den_k};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k] <= '0;
            end
            else if (en)
            begin
                ctl_reg[k] <= ctl_k;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                // borrow set: trial below divisor, keep it
                if (diff[W])
                begin
                    rem_reg[k] <= trial[W-1:0];
                end
                else
                begin
                    rem_reg[k] <= diff[W-1:0];
                end
                low_reg[k] <= {low_k[W-2:0], 1'b0};
                quo_reg[k] <= {quo_k[W-2:0], ~diff[W]};
                den_reg[k] <= den_k;
                ap2_reg[k] <= ap2_k;
                bp2_reg[k] <= bp2_k;
            end
        end
    end

    assign ctl_out = ctl_reg[W-1];
    assign quo     = quo_reg[W-1];
    assign rem_nz  = |rem_reg[W-1];
    assign ap2_out = ap2_reg[W-1];
    assign bp2_out = bp2_reg[W-1];

endmodule

// File: hw/rtl/pseg_back.sv
// ============================================================================
// pseg_back
// Back end: picks the squared distance, then saturates and checks tolerance.
// Two register stages.
// ============================================================================
module pseg_back #(
    parameter int W = 2 * pseg_pkg::COORD_BITS_DEF + 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  pseg_pkg::ctl_t                      ctl_in,
    input  logic [W-1:0]                        quo,
    input  logic                                rem_nz,
    input  logic [W-1:0]                        ap2,
    input  logic [W-1:0]                        bp2,
    input  logic [2*pseg_pkg::TOL_BITS-1:0]     tol_sq,
    output logic                                out_valid,
    output logic [pseg_pkg::DIST_BITS-1:0]      dist_sq,
    output logic                                on_segment
);

    localparam int DB = pseg_pkg::DIST_BITS;
    localparam int TB = 2 * pseg_pkg::TOL_BITS;
    localparam int CW = (W > DB) ? W : DB;
    localparam int TW = (W > TB) ? W : TB;

    // stage A: floor((ap2*ab2 - t^2)/ab2) = ap2 - ceil(t^2/ab2)
    logic [W-1:0] dist_next;
    logic [W-1:0] dist_reg;
    logic         va_reg;

    always_comb
    begin
        case (ctl_in.sel)
            pseg_pkg::SEL_AP:  dist_next = ap2;
            pseg_pkg::SEL_BP:  dist_next = bp2;
            pseg_pkg::SEL_MID: dist_next = ap2 - quo - W'(rem_nz);
            default:           dist_next = ap2;
        endcase
    end

    // stage B: saturate for the port, flag on the full value
    logic [CW-1:0] dist_ext;
    logic [DB-1:0] dist_sq_next;
    logic          on_next;
    logic [DB-1:0] dist_sq_reg;
    logic          on_reg;
    logic          vb_reg;

    always_comb
    begin
        dist_ext = CW'(dist_reg);
        if (dist_ext > CW'({DB{1'b1}}))
        begin
            dist_sq_next = '1;
        end
        else
        begin
            dist_sq_next = DB'(dist_ext);
        end
        on_next = (TW'(dist_reg) <= TW'(tol_sq));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= ctl_in.valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg    <= dist_next;
            dist_sq_reg <= dist_sq_next;
            on_reg      <= on_next;
        end
    end

    assign out_valid  = vb_reg;
    assign dist_sq    = dist_sq_reg;
    assign on_segment = on_reg;

endmodule

// File: hw/rtl/point_segment_distance_core.sv
// ============================================================================
// point_segment_distance_core
// Squared distance from a 3D point to a line segment, with tolerance flag.
// ============================================================================
// Each query transaction carries a point P and segment endpoints A and B as
// signed COORD_BITS-bit integers; each result transaction returns dist_sq,
// the floor of the exact squared distance from P to the nearest point of
// segment AB (saturated to 34 bits), and on_segment, set when that distance
// is at most the tolerance squared. The core is fully pipelined: it
// takes one query per clock while the skid register is empty and returns
// results in order. Its pipeline is the divider, which resolves one
// quotient bit per stage over 2*COORD_BITS + 2 stages, plus four front-end
// and two back-end stages. A result that the sink refuses is parked in a
// skid register; while the skid is full the whole pipeline holds and
// query.ready is low, so each refused result stalls the input. The
// tolerance is to be written through cfg_we / cfg_wdata only while the
// core is idle; the user is bound by this, the core does not enforce it.
// The tolerance resets to zero.
// ============================================================================
module point_segment_distance_core #(
    parameter int COORD_BITS = pseg_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pseg_pkg::TOL_BITS-1:0]     cfg_wdata,
    pseg_query_if.sink                        query,
    pseg_result_if.source                     result
);

    // width of squared lengths and of the divider datapath
    localparam int W  = 2 * COORD_BITS + 2;
    localparam int DB = pseg_pkg::DIST_BITS;
    localparam int TB = pseg_pkg::TOL_BITS;

    // ------------------------------------------------------------------
    // Tolerance register; the square is refreshed every cycle, long
    // before any query that follows a write can reach the back end.
    // ------------------------------------------------------------------
    logic [TB-1:0]   tol_reg;
    logic [2*TB-1:0] tol_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg    <= '0;
            tol_sq_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
            tol_sq_reg <= {{TB{1'b0}}, tol_reg} * {{TB{1'b0}}, tol_reg};
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance. All stages move together; the only thing that
    // holds them is a full skid register.
    // ------------------------------------------------------------------
    logic en;
    logic skid_full_reg;

    assign en          = ~skid_full_reg;
    assign query.ready = en;

    // front end: 4 stages
    pseg_pkg::ctl_t   f_ctl;
    logic [2*W-1:0]   f_tsq;
    logic [W-1:0]     f_ab2;
    logic [W-1:0]     f_ap2;
    logic [W-1:0]     f_bp2;

    pseg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (query.valid),
        .point_x  (query.point_x),
        .point_y  (query.point_y),
        .point_z  (query.point_z),
        .end_a_x  (query.end_a_x),
        .end_a_y  (query.end_a_y),
        .end_a_z  (query.end_a_z),
        .end_b_x  (query.end_b_x),
        .end_b_y  (query.end_b_y),
        .end_b_z  (query.end_b_z),
        .ctl      (f_ctl),
        .tsq      (f_tsq),
        .ab2      (f_ab2),
        .ap2      (f_ap2),
        .bp2      (f_bp2)
    );

    // divider: tnum^2 / |AB|^2, W stages
    pseg_pkg::ctl_t   d_ctl;
    logic [W-1:0]     d_quo;
    logic             d_rem_nz;
    logic [W-1:0]     d_ap2;
    logic [W-1:0]     d_bp2;

    pseg_divider #(
        .W (W)
    ) u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (f_ctl),
        .num_in  (f_tsq),
        .den_in  (f_ab2),
        .ap2_in  (f_ap2),
        .bp2_in  (f_bp2),
        .ctl_out (d_ctl),
        .quo     (d_quo),
        .rem_nz  (d_rem_nz),
        .ap2_out (d_ap2),
        .bp2_out (d_bp2)
    );

    // back end: select, saturate, tolerance compare; 2 stages
    logic          b_valid;
    logic [DB-1:0] b_dist_sq;
    logic          b_on_segment;

    pseg_back #(
        .W (W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .ctl_in     (d_ctl),
        .quo        (d_quo),
        .rem_nz     (d_rem_nz),
        .ap2        (d_ap2),
        .bp2        (d_bp2),
        .tol_sq     (tol_sq_reg),
        .out_valid  (b_valid),
        .dist_sq    (b_dist_sq),
        .on_segment (b_on_segment)
    );

    // ------------------------------------------------------------------
    // Skid register. When the last stage shows a result that the sink
    // does not take, the result moves here and the pipeline freezes on
    // the next cycle. The skid drains first, then the frozen last stage.
    // ------------------------------------------------------------------
    logic          skid_full_next;
    logic [DB-1:0] skid_dist_reg;
    logic          skid_on_reg;

    always_comb
    begin
        skid_full_next = skid_full_reg;
        if (skid_full_reg)
        begin
            if (result.ready)
            begin
                skid_full_next = 1'b0;
            end
        end
        else if (b_valid && !result.ready)
        begin
            skid_full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
        end
        else
        begin
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg && b_valid && !result.ready)
        begin
            skid_dist_reg <= b_dist_sq;
            skid_on_reg   <= b_on_segment;
        end
    end

    assign result.valid      = skid_full_reg | b_valid;
    assign result.dist_sq    = skid_full_reg ? skid_dist_reg : b_dist_sq;
    assign result.on_segment = skid_full_reg ? skid_on_reg : b_on_segment;

endmodule

// File: tb/sv/point_segment_distance_core_test.sv
`timescale 1ns / 100ps
// ============================================================================
// point_segment_distance_core_test
// Self-checking bench: random and corner-case segment queries, scored in order.
// ============================================================================
// Queries go in on the query channel and results come back on the result
// channel. A small scoreboard predicts dist_sq and on_segment for every
// accepted query transaction and compares each result transaction with the
// oldest prediction. The tolerance register is rewritten between phases while
// the pipeline is drained.
// ============================================================================
module point_segment_distance_core_test;

    localparam int CW           = pseg_pkg::COORD_BITS_DEF;
    localparam int DB           = pseg_pkg::DIST_BITS;
    localparam int TB           = pseg_pkg::TOL_BITS;
    localparam int PIPE_LATENCY = 2 * CW + 8;        // core pipeline depth in stages
    localparam int SETTLE       = PIPE_LATENCY + 8;  // quiet time before a cfg write
    localparam int STALL_LIMIT  = 2000;              // cycles without any transaction
    localparam int PHASE_ITEMS  = 190;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct {
        coord_t point_x, point_y, point_z;
        coord_t end_a_x, end_a_y, end_a_z;
        coord_t end_b_x, end_b_y, end_b_z;
    } query_t;

    typedef struct {
        logic [DB-1:0] dist_sq;
        logic          on_segment;
    } result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts each result from the accepted query and the
    // current tolerance, then scores results strictly in order.
    // ------------------------------------------------------------------------
    class seg_distance_board;
        logic [TB-1:0] tolerance;
        result_t       pending_results[$];
        int            mismatches;

        function new();
            tolerance  = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Integer form of the clamped projection. The middle case divides
        // |AP|^2*|AB|^2 - tnum^2 by |AB|^2 with floor, which is exact.
        function void note_query(query_t q);
            longint      dx, dy, dz, ex, ey, ez, fx, fy, fz;
            longint      ab2, ap2, bp2, tnum, dist_val, tol_sq;
            logic [79:0] wide_ap2, wide_ab2, wide_tn, wide_num;
            result_t     r;
            dx   = longint'(q.point_x) - longint'(q.end_a_x);
            dy   = longint'(q.point_y) - longint'(q.end_a_y);
            dz   = longint'(q.point_z) - longint'(q.end_a_z);
            ex   = longint'(q.end_b_x) - longint'(q.end_a_x);
            ey   = longint'(q.end_b_y) - longint'(q.end_a_y);
            ez   = longint'(q.end_b_z) - longint'(q.end_a_z);
            fx   = longint'(q.point_x) - longint'(q.end_b_x);
            fy   = longint'(q.point_y) - longint'(q.end_b_y);
            fz   = longint'(q.point_z) - longint'(q.end_b_z);
            ab2  = ex * ex + ey * ey + ez * ez;
            ap2  = dx * dx + dy * dy + dz * dz;
            bp2  = fx * fx + fy * fy + fz * fz;
            tnum = dx * ex + dy * ey + dz * ez;
            if (ab2 == 0 || tnum <= 0) begin
                dist_val = ap2;
            end
            else if (tnum >= ab2) begin
                dist_val = bp2;
            end
            else begin
                wide_ap2 = ap2;
                wide_ab2 = ab2;
                wide_tn  = tnum;
                wide_num = wide_ap2 * wide_ab2 - wide_tn * wide_tn;
                dist_val = longint'(wide_num / wide_ab2);
            end
            tol_sq = longint'(tolerance) * longint'(tolerance);
            if (dist_val > (64'sd1 <<< DB) - 1)
                r.dist_sq = '1;
            else
                r.dist_sq = dist_val[DB-1:0];
            r.on_segment = (dist_val <= tol_sq);
            pending_results.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: dist_sq %0d on_segment %0b",
                       got.dist_sq, got.on_segment);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.dist_sq !== want.dist_sq) begin
                $error("dist_sq mismatch: expected %0d, actual %0d",
                       want.dist_sq, got.dist_sq);
                mismatches++;
            end
            if (got.on_segment !== want.on_segment) begin
                $error("on_segment mismatch: expected %0b, actual %0b",
                       want.on_segment, got.on_segment);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels, core
    // ------------------------------------------------------------------------
    logic          clk;
    logic          rst_n;
    logic          cfg_we;
    logic [TB-1:0] cfg_wdata;
    bit            steady_flow;   // both sides run with no idle cycles

    seg_distance_board board = new();

    pseg_query_if #(.COORD_BITS(CW)) query_ch ();
    pseg_result_if                   result_ch ();

    point_segment_distance_core #(.COORD_BITS(CW)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .query     (query_ch.sink),
        .result    (result_ch.source)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int rnd_in(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic query_t mk(int px, int py, int pz, int ax, int ay, int az,
                                  int bx, int by, int bz);
        query_t q;
        q.point_x = coord_t'(px);
        q.point_y = coord_t'(py);
        q.point_z = coord_t'(pz);
        q.end_a_x = coord_t'(ax);
        q.end_a_y = coord_t'(ay);
        q.end_a_z = coord_t'(az);
        q.end_b_x = coord_t'(bx);
        q.end_b_y = coord_t'(by);
        q.end_b_z = coord_t'(bz);
        return q;
    endfunction

    // Mix of query shapes. Plain random coordinates almost always land far
    // from the segment, so most queries are built around a segment instead.
    function automatic query_t random_query();
        int p[3];
        int a[3];
        int b[3];
        int d[3];
        int kind, span, len, k;
        kind = $urandom_range(0, 99);
        if (kind < 20) begin
            // full-range noise, exercises every input bit
            for (int i = 0; i < 3; i++)
            begin
                p[i] = rnd_in(-32768, 32767);
                a[i] = rnd_in(-32768, 32767);
                b[i] = rnd_in(-32768, 32767);
            end
        end
        else if (kind < 50) begin
            // local cluster, all three points near one base
            case ($urandom_range(0, 2))
                0:       span = 15;
                1:       span = 255;
                default: span = 4095;
            endcase
            for (int i = 0; i < 3; i++)
            begin
                d[i] = rnd_in(-28000, 28000);
                p[i] = rnd_in(d[i] - span, d[i] + span);
                a[i] = rnd_in(d[i] - span, d[i] + span);
                b[i] = rnd_in(d[i] - span, d[i] + span);
            end
        end
        else if (kind < 80) begin
            // point on or next to the line AB, a few steps past either end too
            len = rnd_in(1, 64);
            k   = rnd_in(-3, len + 3);
            for (int i = 0; i < 3; i++)
            begin
                a[i] = rnd_in(-20000, 20000);
                d[i] = rnd_in(-64, 64);
                b[i] = a[i] + d[i] * len;
                p[i] = a[i] + d[i] * k + ($urandom_range(0, 1) ? rnd_in(-2, 2) : 0);
            end
        end
        else if (kind < 90) begin
            // degenerate segment
            for (int i = 0; i < 3; i++)
            begin
                a[i] = rnd_in(-32768, 32767);
                b[i] = a[i];
                p[i] = $urandom_range(0, 1) ? rnd_in(-32768, 32767) : a[i] + rnd_in(-255, 255);
            end
        end
        else begin
            // coordinates at or next to the range limits or zero, or random
            for (int i = 0; i < 9; i++)
            begin
                case ($urandom_range(0, 7))
                    0:       d[0] = -32768;
                    1:       d[0] = -32767;
                    2:       d[0] = -1;
                    3:       d[0] = 0;
                    4:       d[0] = 1;
                    5:       d[0] = 32766;
                    6:       d[0] = 32767;
                    default: d[0] = rnd_in(-32768, 32767);
                endcase
                if (i < 3)      p[i]     = d[0];
                else if (i < 6) a[i - 3] = d[0];
                else            b[i - 6] = d[0];
            end
        end
        return mk(p[0], p[1], p[2], a[0], a[1], a[2], b[0], b[1], b[2]);
    endfunction

    // ------------------------------------------------------------------------
    // Drivers. All inputs change by NBA right after a rising edge; ready and
    // valid are sampled in the same active region, so they hold pre-edge values.
    // ------------------------------------------------------------------------
    task automatic send_query(query_t q);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            query_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        query_ch.valid   <= 1'b1;
        query_ch.point_x <= q.point_x;
        query_ch.point_y <= q.point_y;
        query_ch.point_z <= q.point_z;
        query_ch.end_a_x <= q.end_a_x;
        query_ch.end_a_y <= q.end_a_y;
        query_ch.end_a_z <= q.end_a_z;
        query_ch.end_b_x <= q.end_b_x;
        query_ch.end_b_y <= q.end_b_y;
        query_ch.end_b_z <= q.end_b_z;
        do
            @(posedge clk);
        while (!query_ch.ready);
    endtask

    // Stop sending, let every pending result come back, then let the
    // pipeline run empty before anything touches the tolerance register.
    task automatic drain_pipeline();
        query_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_tolerance(logic [TB-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.tolerance = value;
    endtask

    // Corner cases: range limits, degenerate segment, projection before A,
    // exactly at A, past B, exactly at B, inside with exact and floored
    // results, and a flag boundary at distance squared 9 versus 10.
    task automatic send_corner_queries();
        send_query(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_query(mk(-32768, -32768, -32768, -32768, -32768, -32768,
                      -32768, -32768, -32768));
        send_query(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_query(mk(32767, 32767, 32767, -32768, -32768, -32768,
                      -32768, -32768, -32768));
        send_query(mk(-32768, -32768, -32768, -32768, -32768, -32768,
                      32767, 32767, 32767));
        send_query(mk(32767, 32767, 32767, -32768, -32768, -32768,
                      32767, 32767, 32767));
        send_query(mk(32767, -32768, 32767, -32768, 32767, -32768,
                      32767, 32767, 32767));
        send_query(mk(32767, -32768, 0, -32768, -32768, -32768, 32767, 32767, 32767));
        send_query(mk(-32768, 32767, -32768, 32767, 32767, 32767,
                      -32768, -32768, -32768));
        send_query(mk(-50, 7, 0, 0, 0, 0, 100, 0, 0));
        send_query(mk(0, 20, 0, 0, 0, 0, 100, 0, 0));
        send_query(mk(200, -5, 3, 0, 0, 0, 100, 0, 0));
        send_query(mk(100, 9, 9, 0, 0, 0, 100, 0, 0));
        send_query(mk(50, 3, 0, 0, 0, 0, 100, 0, 0));
        send_query(mk(50, 3, 1, 0, 0, 0, 100, 0, 0));
        send_query(mk(5, -2, 4, 0, 0, 0, 3, 7, 11));
        send_query(mk(0, 0, 0, -10, -20, -30, 10, 20, 30));
        send_query(mk(1, 0, 0, 0, 0, 0, 1, 1, 1));
        send_query(mk(-32768, 32767, -1, 1234, -4321, 77, 1234, -4321, 77));
        send_query(mk(5, 5, 0, 0, 0, 0, 0, 0, 1));
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure, drawn per result transaction
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int gap;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = steady_flow ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every accepted transaction goes to the scoreboard
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        query_t  seen_q;
        result_t seen_r;
        if (rst_n) begin
            if (query_ch.valid && query_ch.ready) begin
                seen_q.point_x = query_ch.point_x;
                seen_q.point_y = query_ch.point_y;
                seen_q.point_z = query_ch.point_z;
                seen_q.end_a_x = query_ch.end_a_x;
                seen_q.end_a_y = query_ch.end_a_y;
                seen_q.end_a_z = query_ch.end_a_z;
                seen_q.end_b_x = query_ch.end_b_x;
                seen_q.end_b_y = query_ch.end_b_y;
                seen_q.end_b_z = query_ch.end_b_z;
                board.note_query(seen_q);
            end
            if (result_ch.valid && result_ch.ready) begin
                seen_r.dist_sq    = result_ch.dist_sq;
                seen_r.on_segment = result_ch.on_segment;
                board.check_result(seen_r);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a long run of cycles with no transaction means a hang
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** point_segment_distance_core: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        logic [TB-1:0] tol_plan[7];
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        steady_flow      = 1'b0;
        query_ch.valid   = 1'b0;
        query_ch.point_x = '0;
        query_ch.point_y = '0;
        query_ch.point_z = '0;
        query_ch.end_a_x = '0;
        query_ch.end_a_y = '0;
        query_ch.end_a_z = '0;
        query_ch.end_b_x = '0;
        query_ch.end_b_y = '0;
        query_ch.end_b_z = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners at the reset tolerance of zero, then again at tolerance 3
        send_corner_queries();
        drain_pipeline();
        write_tolerance(16'd3);
        send_corner_queries();

        // random phases, each at its own tolerance; extremes included
        tol_plan[0] = 16'hFFFF;
        tol_plan[1] = 16'd0;
        tol_plan[2] = 16'd1;
        tol_plan[3] = 16'h8000;
        tol_plan[4] = TB'($urandom_range(0, 4095));
        tol_plan[5] = TB'($urandom_range(0, 65535));
        tol_plan[6] = TB'($urandom_range(2, 40));
        for (int ph = 0; ph < 7; ph++)
        begin
            drain_pipeline();
            write_tolerance(tol_plan[ph]);
            steady_flow = (ph == 2 || ph == 5);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // mid-phase hold-off: sender waits for the core to empty
                if (ph == 3 && n == PHASE_ITEMS / 2) begin
                    query_ch.valid <= 1'b0;
                    while (board.pending() != 0) @(posedge clk);
                end
                send_query(random_query());
            end
        end
        steady_flow = 1'b0;

        query_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (board.mismatches == 0 && board.pending() == 0)
            $display("** point_segment_distance_core: PASSED **");
        else
            $display("** point_segment_distance_core: FAILED **");
        $finish;
    end

endmodule
